FILE: sv/csp_pkg.sv
// Shared types and codes of the chunk stream parser.
package csp_pkg;

  // Parse phases
  localparam logic [3:0] PH_START         = 4'd0;
  localparam logic [3:0] PH_DOC_OR_END    = 4'd1;
  localparam logic [3:0] PH_DOC_ID        = 4'd2;
  localparam logic [3:0] PH_DOC_NUL       = 4'd3;
  localparam logic [3:0] PH_STREAM_OR_END = 4'd4;
  localparam logic [3:0] PH_STREAM_ID     = 4'd5;
  localparam logic [3:0] PH_STREAM_NUL    = 4'd6;
  localparam logic [3:0] PH_TERM_OR_END   = 4'd7;
  localparam logic [3:0] PH_TERM          = 4'd8;
  localparam logic [3:0] PH_DONE          = 4'd9;
  localparam logic [3:0] PH_FAULT         = 4'd10;

  // Event codes
  localparam logic [3:0] EV_FILE_ENTER   = 4'd0;
  localparam logic [3:0] EV_FILE_EXIT    = 4'd1;
  localparam logic [3:0] EV_DOC_ENTER    = 4'd2;
  localparam logic [3:0] EV_DOC_EXIT     = 4'd3;
  localparam logic [3:0] EV_STREAM_ENTER = 4'd4;
  localparam logic [3:0] EV_STREAM_EXIT  = 4'd5;
  localparam logic [3:0] EV_TERM_BYTE    = 4'd6;
  localparam logic [3:0] EV_TERM_END     = 4'd7;
  localparam logic [3:0] EV_ERROR        = 4'd8;

  // Error codes
  localparam logic [1:0] ERR_HEX   = 2'd0;
  localparam logic [1:0] ERR_NUL   = 2'd1;
  localparam logic [1:0] ERR_TRUNC = 2'd2;

  // Characters
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_A    = 8'h61;
  localparam logic [7:0] CH_F    = 8'h66;

  typedef struct packed {
    logic [3:0]  ev;
    logic [63:0] value;
    logic [1:0]  code;
  } event_t;

  // Events caused by one byte: e0 always, e1 when two is set
  typedef struct packed {
    logic   two;
    event_t e0;
    event_t e1;
  } bundle_t;

endpackage

FILE: sv/csp_in_if.sv
// Byte input channel of the chunk stream parser.
interface csp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: sv/csp_out_if.sv
// Event output channel of the chunk stream parser.
interface csp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_res;
  logic [63:0] value;
  logic [1:0]  error_code;

  modport source (output valid, output event_res, output value, output error_code,
                  input ready);
  modport sink (input valid, input event_res, input value, input error_code,
                output ready);
endinterface

FILE: sv/csp_front.sv
// Front end: accepts bytes, runs the parse state and bundles the events of each byte.
module csp_front #(
  parameter int unsigned DOC_ID_DIGITS    = 16,
  parameter int unsigned STREAM_ID_DIGITS = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  csp_in_if.sink           in_ch,
  output logic             push_valid,
  output csp_pkg::bundle_t push_data,
  input  logic             push_ready
);
  import csp_pkg::*;

  localparam logic [4:0] DOC_LIM    = 5'(DOC_ID_DIGITS);
  localparam logic [4:0] STREAM_LIM = 5'(STREAM_ID_DIGITS);

  logic [3:0]  phase_r, phase_nxt;
  logic [4:0]  dcnt_r, dcnt_nxt;
  logic [63:0] acc_r, acc_nxt;

  logic        accept;
  logic [7:0]  b;
  logic [3:0]  ph;
  logic        file_ev, main_v, trunc_v;
  event_t      main_e, file_e, trunc_e, slot1_e;
  logic        is_hex;
  logic [3:0]  nib;
  logic        dig_start, dig_doc;
  logic [63:0] base_acc;
  logic [4:0]  base_cnt, cnt_inc, dig_lim;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;
  assign b           = in_ch.data_byte;

  always_comb begin
    is_hex = 1'b0;
    nib    = '0;
    if (b inside {[CH_ZERO:CH_NINE]}) begin
      is_hex = 1'b1;
      nib    = 4'(b - CH_ZERO);
    end else if (b inside {[CH_A:CH_F]}) begin
      is_hex = 1'b1;
      nib    = 4'(b - CH_A + 8'd10);
    end
  end

  always_comb begin
    file_ev   = (phase_r == PH_START);
    ph        = file_ev ? PH_DOC_OR_END : phase_r;
    // Id digit path: a hex digit in a list phase starts a fresh id
    dig_start = (ph == PH_DOC_OR_END) || (ph == PH_STREAM_OR_END);
    dig_doc   = (ph == PH_DOC_OR_END) || (ph == PH_DOC_ID);
    base_acc  = dig_start ? '0 : acc_r;
    base_cnt  = dig_start ? '0 : dcnt_r;
    cnt_inc   = base_cnt + 5'd1;
    dig_lim   = dig_doc ? DOC_LIM : STREAM_LIM;

    phase_nxt = ph;
    dcnt_nxt  = dcnt_r;
    acc_nxt   = acc_r;
    main_v    = 1'b0;
    main_e    = '{ev: EV_ERROR, value: '0, code: ERR_HEX};

    case (ph)
      PH_DOC_OR_END, PH_DOC_ID, PH_STREAM_OR_END, PH_STREAM_ID: begin
        if (dig_start && b == CH_NUL) begin
          main_v    = 1'b1;
          main_e.ev = (ph == PH_DOC_OR_END) ? EV_FILE_EXIT : EV_DOC_EXIT;
          phase_nxt = (ph == PH_DOC_OR_END) ? PH_DONE : PH_DOC_OR_END;
        end else if (!is_hex) begin
          main_v    = 1'b1;
          phase_nxt = PH_FAULT;
        end else begin
          acc_nxt  = {base_acc[59:0], nib};
          dcnt_nxt = cnt_inc;
          if (cnt_inc >= dig_lim) begin
            phase_nxt = dig_doc ? PH_DOC_NUL : PH_STREAM_NUL;
          end else begin
            phase_nxt = dig_doc ? PH_DOC_ID : PH_STREAM_ID;
          end
        end
      end
      PH_DOC_NUL, PH_STREAM_NUL: begin
        main_v = 1'b1;
        if (b == CH_NUL) begin
          main_e.ev    = (ph == PH_DOC_NUL) ? EV_DOC_ENTER : EV_STREAM_ENTER;
          main_e.value = acc_r;
          phase_nxt    = (ph == PH_DOC_NUL) ? PH_STREAM_OR_END : PH_TERM_OR_END;
        end else begin
          main_e.code = ERR_NUL;
          phase_nxt   = PH_FAULT;
        end
      end
      PH_TERM_OR_END, PH_TERM: begin
        main_v = 1'b1;
        if (b == CH_NUL) begin
          main_e.ev = (ph == PH_TERM_OR_END) ? EV_STREAM_EXIT : EV_TERM_END;
          phase_nxt = (ph == PH_TERM_OR_END) ? PH_STREAM_OR_END : PH_TERM_OR_END;
        end else begin
          main_e.ev    = EV_TERM_BYTE;
          main_e.value = {56'd0, b};
          phase_nxt    = PH_TERM;
        end
      end
      default: begin
        // closed or faulted: drop the byte
        if (ph != PH_DONE) begin
          phase_nxt = PH_FAULT;
        end
      end
    endcase

    trunc_v = in_ch.last_byte &&
              (phase_r != PH_DONE) && (phase_r != PH_FAULT) &&
              (phase_nxt != PH_DONE) && (phase_nxt != PH_FAULT);

    // Last byte rearms the parser
    if (in_ch.last_byte) begin
      phase_nxt = PH_START;
      dcnt_nxt  = '0;
      acc_nxt   = '0;
    end
  end

  // Pack up to two events in order: file enter, byte event, truncation
  always_comb begin
    file_e  = '{ev: EV_FILE_ENTER, value: '0, code: ERR_HEX};
    trunc_e = '{ev: EV_ERROR, value: '0, code: ERR_TRUNC};
    slot1_e = main_v ? main_e : trunc_e;
    push_data.e0  = file_ev ? file_e : slot1_e;
    push_data.e1  = file_ev ? slot1_e : trunc_e;
    push_data.two = (file_ev && (main_v || trunc_v)) || (main_v && trunc_v);
    push_valid    = accept && (file_ev || main_v || trunc_v);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      dcnt_r  <= '0;
      acc_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      dcnt_r  <= dcnt_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule

FILE: sv/csp_queue.sv
// Two-entry bundle queue between the parse front end and the event back end.
module csp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  csp_pkg::bundle_t push_data,
  output logic             push_ready,
  output logic             pop_valid,
  output csp_pkg::bundle_t pop_data,
  input  logic             pop_ready
);
  import csp_pkg::*;

  bundle_t    mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: sv/csp_back.sv
// Back end: splits each bundle into single events behind an output register.
module csp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  input  csp_pkg::bundle_t pop_data,
  output logic             pop_ready,
  csp_out_if.source        out_ch
);
  import csp_pkg::*;

  logic   sel_r, sel_nxt;
  logic   ov_r;
  event_t ev_r;
  logic   load;

  assign load      = pop_valid && (!ov_r || out_ch.ready);
  assign pop_ready = load && (sel_r || !pop_data.two);
  assign sel_nxt   = !sel_r && pop_data.two;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      sel_r <= 1'b0;
    end else if (load) begin
      ov_r  <= 1'b1;
      sel_r <= sel_nxt;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ev_r <= sel_r ? pop_data.e1 : pop_data.e0;
    end
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.event_res  = ev_r.ev;
  assign out_ch.value      = ev_r.value;
  assign out_ch.error_code = ev_r.code;

endmodule

FILE: sv/chunk_stream_parser_core.sv
// Chunk stream parser top level: byte in, parse events out.
// Path: an accepted byte's bundle is written into the queue, then its first event
// into the output register; a second event of the same byte follows the first there.
// Throughput: one byte per cycle while the queue has room; output drains one event per
// cycle, so a two-event byte leaves the queue after both. ID digits cause no event of their own.
// Reset (synchronous, rst_n low): parser waits for the first byte of a chunk,
// queue and output register are empty.
module chunk_stream_parser_core #(
  parameter int unsigned DOC_ID_DIGITS    = 16,
  parameter int unsigned STREAM_ID_DIGITS = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  csp_in_if.sink    in_ch,
  csp_out_if.source out_ch
);
  import csp_pkg::*;

  // Front to queue
  logic    push_valid, push_ready;
  bundle_t push_data;
  // Queue to back
  logic    pop_valid, pop_ready;
  bundle_t pop_data;

  // Parse each accepted byte; hold input while the queue is full
  csp_front #(
    .DOC_ID_DIGITS    (DOC_ID_DIGITS),
    .STREAM_ID_DIGITS (STREAM_ID_DIGITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  // Decouple parsing from output stalls
  csp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  // Advance one event per cycle into the output register while out_ch.ready allows
  csp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

  // Error code is only meaningful on error events
  a_code_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.event_res != EV_ERROR) |-> out_ch.error_code == ERR_HEX)
    else $error("error code set on a non-error event");

  // Value carries data only for doc enter, stream enter and term byte
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.event_res != EV_DOC_ENTER) &&
    (out_ch.event_res != EV_STREAM_ENTER) && (out_ch.event_res != EV_TERM_BYTE)
    |-> out_ch.value == 64'd0)
    else $error("nonzero value on an event without data");

  // Nothing comes out right after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_ch.valid)
    else $error("output valid right after reset");

  // A bundle with a second event never leaves the queue on its first event
  a_two_event_split: assert property (@(posedge clk) disable iff (!rst_n)
    pop_valid && pop_ready |-> !pop_data.two || $past(pop_valid && !pop_ready))
    else $error("two-event bundle popped without emitting its first event");

endmodule
